>>> design/msc_pkg.sv
// Shared types and constants for the matrix symmetry checker.
`timescale 1ns / 1ps

package msc_pkg;

  localparam int ELEM_W = 32;
  localparam int ORDER_W = 5;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;
  localparam int DEFAULT_MAX_ORDER = 16;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int RESULT_W = 8;

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [ELEM_W-1:0] mirror;
    logic              check;  // element lies on or below the diagonal
    logic              last;   // final element of the matrix
  } item_t;

endpackage

>>> design/msc_front.sv
// Front end: element intake, index tracking, element store and mirror fetch.
`timescale 1ns / 1ps

module msc_front #(
  parameter int MAX_ORDER = msc_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [msc_pkg::ORDER_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [msc_pkg::ELEM_W-1:0] in_element,
  input  logic [msc_pkg::QCNT_W-1:0] q_count,
  output logic                       push,
  output msc_pkg::item_t             push_item
);
  import msc_pkg::*;

  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ORDER_CAP = (MAX_ORDER > 31) ? 31 : MAX_ORDER;
  localparam int CW = (IDX_W > ORDER_W) ? IDX_W : ORDER_W;

  logic [ELEM_W-1:0] store [DEPTH];

  logic [ORDER_W-1:0] order;
  logic [ORDER_W-1:0] n_eff;
  logic [ORDER_W-1:0] last_idx;
  logic [IDX_W-1:0]   row;
  logic [IDX_W-1:0]   col;
  logic [IDX_W-1:0]   row_next;
  logic [IDX_W-1:0]   col_next;
  logic               row_last;
  logic               col_last;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               accept;

  logic              s1_valid;
  logic [ELEM_W-1:0] s1_element;
  logic              s1_check;
  logic              s1_diag;
  logic              s1_last;
  logic [ELEM_W-1:0] rd_data;

  // Reserve a queue slot for the element held in the fetch stage; hold off
  // intake during reset and order writes.
  assign in_ready = !rst && !cfg_we &&
                    ((QCNT_W'(q_count) + QCNT_W'(s1_valid)) < QCNT_W'(QUEUE_DEPTH));
  assign accept = in_valid && in_ready;

  always_comb begin
    if (order == '0) begin
      n_eff = ORDER_W'(1);
    end else if (32'(order) > ORDER_CAP) begin
      n_eff = ORDER_W'(ORDER_CAP);
    end else begin
      n_eff = order;
    end
  end

  assign last_idx = n_eff - ORDER_W'(1);
  assign row_last = (CW'(row) == CW'(last_idx));
  assign col_last = (CW'(col) == CW'(last_idx));

  assign wr_addr = ADDR_W'(row) * ADDR_W'(MAX_ORDER) + ADDR_W'(col);
  assign rd_addr = ADDR_W'(col) * ADDR_W'(MAX_ORDER) + ADDR_W'(row);

  always_comb begin
    row_next = row;
    col_next = col;
    if (col_last) begin
      col_next = '0;
      row_next = row_last ? '0 : row + IDX_W'(1);
    end else begin
      col_next = col + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= ORDER_RESET;
      row <= '0;
      col <= '0;
      s1_valid <= 1'b0;
    end else if (cfg_we) begin
      // Drop any partial matrix.
      order <= cfg_data;
      row <= '0;
      col <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        row <= row_next;
        col <= col_next;
      end
    end
  end

  // The mirror of a below-diagonal element was written at least one
  // transaction earlier, so read-after-write ordering holds.
  always_ff @(posedge clk) begin
    if (accept) begin
      store[wr_addr] <= in_element;
      rd_data <= store[rd_addr];
      s1_element <= in_element;
      s1_check <= (col <= row);
      s1_diag <= (col == row);
      s1_last <= row_last && col_last;
    end
  end

  assign push = s1_valid;
  assign push_item.element = s1_element;
  assign push_item.mirror = s1_diag ? s1_element : rd_data;
  assign push_item.check = s1_check;
  assign push_item.last = s1_last;

endmodule

>>> design/msc_queue.sv
// Short queue between the front end and the comparison back end.
`timescale 1ns / 1ps

module msc_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  msc_pkg::item_t             push_item,
  input  logic                       pop,
  output logic                       q_valid,
  output msc_pkg::item_t             q_item,
  output logic [msc_pkg::QCNT_W-1:0] q_count
);
  import msc_pkg::*;

  item_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_item = slots[rd_ptr];
  assign q_count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> design/msc_back.sv
// Back end: mirror comparison, running flags and the result register.
`timescale 1ns / 1ps

module msc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         q_valid,
  input  msc_pkg::item_t               q_item,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [msc_pkg::RESULT_W-1:0] out_data
);
  import msc_pkg::*;

  logic symmetric_so_far;
  logic skew_so_far;
  logic sym_next;
  logic skew_next;
  logic sym_hit;
  logic skew_hit;
  logic res_sym;
  logic res_skew;

  assign sym_hit = (q_item.element == q_item.mirror);
  assign skew_hit = (q_item.element == (ELEM_W'(0) - q_item.mirror));

  assign sym_next = symmetric_so_far && (!q_item.check || sym_hit);
  assign skew_next = skew_so_far && (!q_item.check || skew_hit);

  // Only the final element needs a free result register.
  assign pop = q_valid && (!q_item.last || !out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      symmetric_so_far <= 1'b1;
      skew_so_far <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (!cfg_we && pop && q_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        symmetric_so_far <= 1'b1;
        skew_so_far <= 1'b1;
      end else if (pop) begin
        if (q_item.last) begin
          symmetric_so_far <= 1'b1;
          skew_so_far <= 1'b1;
        end else begin
          symmetric_so_far <= sym_next;
          skew_so_far <= skew_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.last) begin
      res_sym <= sym_next;
      res_skew <= skew_next;
    end
  end

  assign out_data = {{(RESULT_W - 2){1'b0}}, res_skew, res_sym};

endmodule

>>> design/matrix_symmetry_checker_top.sv
// Top level of the matrix symmetry checker.
//
//  Channel   Direction  Signals                      Content
//  s_axis    in         s_tvalid s_tready s_tdata    element [31:0]
//  m_axis    out        m_tvalid m_tready m_tdata    sym_match [0], is_skew_symmetric [1]
//  cfg       in         cfg_we cfg_data              order [4:0]
//
// Sustains one element per cycle while the queue has room; the element store
// takes one write and one mirror read per cycle. m_tvalid is registered behind
// the fetch stage and the queue slot that carry the final element. A synchronous
// rst restores order 16 and an empty matrix; the store holds no reset. A stalled
// m_axis fills the four-entry queue and then drops s_tready.
`timescale 1ns / 1ps

module matrix_symmetry_checker_top #(
  parameter int MAX_ORDER = msc_pkg::DEFAULT_MAX_ORDER
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msc_pkg::ORDER_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [msc_pkg::ELEM_W-1:0]    s_tdata,   // [31:0] element
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [msc_pkg::RESULT_W-1:0]  m_tdata    // [0] sym_match, [1] is_skew_symmetric
);
  import msc_pkg::*;

  logic              push;
  item_t             push_item;
  logic              pop;
  logic              q_valid;
  item_t             q_item;
  logic [QCNT_W-1:0] q_count;

  msc_front #(
    .MAX_ORDER(MAX_ORDER)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_element(s_tdata),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  msc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_count  (q_count)
  );

  msc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (m_tdata)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the matrix symmetry checker: directed table plus random matrices.
`timescale 1ns / 1ps

module tb_top;
  import msc_pkg::*;

  localparam int MAX_ORDER      = DEFAULT_MAX_ORDER;
  localparam int ITEMS_TARGET   = 850;
  localparam int SETTLE_CYCLES  = 8;     // settle margin after the last result
  localparam int DRAIN_CYCLES   = 12;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic is_skew;
    logic is_sym;
  } flags_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_ELEM} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        typed;
    flags_t      want;
  } stim_row_t;

  typedef enum int {SHAPE_SYMMETRIC, SHAPE_SKEW, SHAPE_BOTH, SHAPE_NOISE} shape_e;

  // Typed results only where obvious: 1x1 matrices and the order-zero case.
  localparam int N_ROWS = 27;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_CFG,  32'd1,         1'b0, 2'b00},
    '{ROW_ELEM, 32'h0000_0000, 1'b1, 2'b11},
    '{ROW_ELEM, 32'h8000_0000, 1'b1, 2'b11},
    '{ROW_ELEM, 32'h7FFF_FFFF, 1'b1, 2'b01},
    '{ROW_ELEM, 32'hFFFF_FFFF, 1'b1, 2'b01},
    '{ROW_CFG,  32'd0,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd5,         1'b1, 2'b01},
    '{ROW_CFG,  32'd2,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd0,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd1,         1'b0, 2'b00},
    '{ROW_ELEM, 32'hFFFF_FFFF, 1'b0, 2'b00},
    '{ROW_ELEM, 32'd0,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd3,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd7,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd7,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd3,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd9,         1'b0, 2'b00},
    // order write with one element pending: partial matrix is dropped
    '{ROW_CFG,  32'd3,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd0,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd2,         1'b0, 2'b00},
    '{ROW_ELEM, 32'hFFFF_FFFD, 1'b0, 2'b00},
    '{ROW_ELEM, 32'hFFFF_FFFE, 1'b0, 2'b00},
    '{ROW_ELEM, 32'd0,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd5,         1'b0, 2'b00},
    '{ROW_ELEM, 32'd3,         1'b0, 2'b00},
    '{ROW_ELEM, 32'hFFFF_FFFB, 1'b0, 2'b00},
    '{ROW_ELEM, 32'd0,         1'b0, 2'b00}
  };

  logic                clk;
  logic                rst      = 1'b1;
  logic                cfg_we   = 1'b0;
  logic [ORDER_W-1:0]  cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ELEM_W-1:0]   s_tdata  = '0;    // [31:0] element
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;          // [0] sym_match, [1] is_skew_symmetric

  // Predictor state
  logic [ORDER_W-1:0] order_reg;
  int                 cur_row;
  int                 cur_col;
  logic               sym_so_far;
  logic               skew_so_far;
  logic [31:0]        mirror_store [MAX_ORDER*MAX_ORDER];

  flags_t      pending_flags [$];
  logic [31:0] matrix_buf [MAX_ORDER][MAX_ORDER];

  int error_count    = 0;
  int elements_sent  = 0;
  int results_seen   = 0;
  int sym_results    = 0;
  int skew_results   = 0;
  int order_writes   = 0;
  int burst_left     = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int rx_mode        = 0;
  int rx_mode_left   = 0;
  int stall_cycles   = 0;

  matrix_symmetry_checker_top #(.MAX_ORDER(MAX_ORDER)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int effective_order(input logic [ORDER_W-1:0] ord);
    if (ord == 0) return 1;
    if (ord > MAX_ORDER) return MAX_ORDER;
    return int'(ord);
  endfunction

  function automatic void restart_matrix();
    cur_row     = 0;
    cur_col     = 0;
    sym_so_far  = 1'b1;
    skew_so_far = 1'b1;
  endfunction

  // Fold one element into the running flags; returns 1 on the final element.
  function automatic logic next_symmetry_flags(input logic [31:0] x, output flags_t res);
    int          n;
    int          r;
    int          c;
    logic [31:0] mirror;
    n   = effective_order(order_reg);
    r   = cur_row;
    c   = cur_col;
    res = '0;
    if (r >= n || c >= n) begin
      r = 0;
      c = 0;
    end
    mirror_store[(r * MAX_ORDER + c) % (MAX_ORDER * MAX_ORDER)] = x;
    if (c <= r) begin
      mirror = mirror_store[(c * MAX_ORDER + r) % (MAX_ORDER * MAX_ORDER)];
      if (x != mirror) sym_so_far = 1'b0;
      if (x != 32'd0 - mirror) skew_so_far = 1'b0;
    end
    if (r == n - 1 && c == n - 1) begin
      res.is_sym  = sym_so_far;
      res.is_skew = skew_so_far;
      restart_matrix();
      return 1'b1;
    end
    if (c == n - 1) begin
      cur_col = 0;
      cur_row = r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  task automatic check_result(input logic [RESULT_W-1:0] data);
    flags_t want;
    if (pending_flags.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(data), 32'd0);
    end else begin
      want = pending_flags.pop_front();
      if (data[0] !== want.is_sym)
        report_mismatch("sym_match", 32'(data[0]), 32'(want.is_sym));
      if (data[1] !== want.is_skew)
        report_mismatch("is_skew_symmetric", 32'(data[1]), 32'(want.is_skew));
      if (data[RESULT_W-1:2] !== '0) report_mismatch("tdata padding", 32'(data), 32'd0);
      results_seen++;
      if (want.is_sym) sym_results++;
      if (want.is_skew) skew_results++;
    end
  endtask

  // Wait for the block to go idle, then load a new order.
  task automatic write_order(input logic [ORDER_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_reg  = value;
    restart_matrix();
    order_writes++;
  endtask

  task automatic send_element(input logic [31:0] x, input logic typed, input flags_t want);
    int     gap;
    flags_t res;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    elements_sent++;
    if (next_symmetry_flags(x, res)) pending_flags.push_back(typed ? want : res);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_matrix(input int n, input shape_e shape);
    int r;
    int c;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        case (shape)
          SHAPE_SYMMETRIC: matrix_buf[r][c] = (c < r) ? matrix_buf[c][r] : pick_word();
          SHAPE_SKEW: begin
            if (c < r) matrix_buf[r][c] = 32'd0 - matrix_buf[c][r];
            else if (c == r) matrix_buf[r][c] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
            else matrix_buf[r][c] = pick_word();
          end
          SHAPE_BOTH: begin
            if (c < r) matrix_buf[r][c] = matrix_buf[c][r];
            else matrix_buf[r][c] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'd0;
          end
          default: matrix_buf[r][c] = pick_word();
        endcase
      end
    end
    // break a well-formed matrix in a single bit now and then
    if (shape != SHAPE_NOISE && $urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, n - 1);
      c = $urandom_range(0, n - 1);
      matrix_buf[r][c][$urandom_range(0, 31)] ^= 1'b1;
    end
  endtask

  task automatic stream_matrix(input int n, input int count);
    int k;
    for (k = 0; k < count; k++)
      send_element(matrix_buf[k / n][k % n], 1'b0, '0);
  endtask

  task automatic run_phase(input logic [ORDER_W-1:0] ord, input int matrices,
                           input logic allow_partial, input logic long_hold);
    int n;
    int m;
    n = effective_order(ord);
    write_order(ord);
    if (long_hold) hold_req <= hold_req + 1;
    for (m = 0; m < matrices && elements_sent < ITEMS_TARGET; m++) begin
      fill_matrix(n, shape_e'($urandom_range(0, 3)));
      stream_matrix(n, n * n);
    end
    // leave a partial matrix behind for the next order write to drop
    if (allow_partial && n > 1 && elements_sent < ITEMS_TARGET &&
        $urandom_range(0, 3) == 0) begin
      fill_matrix(n, shape_e'($urandom_range(0, 3)));
      stream_matrix(n, $urandom_range(1, (n * n - 1 < 40) ? n * n - 1 : 40));
    end
  endtask

  function automatic logic [ORDER_W-1:0] pick_order();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'($urandom_range(7, 15));
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  // Receiver: check on each transaction, stall on its own pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int i;
    order_reg = ORDER_RESET;
    restart_matrix();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG)
        write_order(DIRECTED_ROWS[i].value[ORDER_W-1:0]);
      else
        send_element(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    run_phase(5'd16, 1, 1'b0, 1'b0);
    run_phase(5'd31, 1, 1'b1, 1'b0);
    // 1x1 matrices under a long output stall: fill the queue and back up
    run_phase(5'd1, 40, 1'b0, 1'b1);
    while (elements_sent < ITEMS_TARGET)
      run_phase(pick_order(), $urandom_range(2, 6), 1'b1, 1'b0);

    s_tvalid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d elements over %0d order writes (orders 0, 1, 16, 31 and random)",
             elements_sent, order_writes);
    $display("covered: %0d results, %0d symmetric, %0d skew-symmetric, %0d errors",
             results_seen, sym_results, skew_results, error_count);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
